// ----- hdl/dirty_cell_display_refresh_defines.svh -----
// assertion macros used by the dirty cell display refresh back end
// expects clk and rst_n in the scope of each use
`ifndef DIRTY_CELL_DISPLAY_REFRESH_DEFINES_SVH
`define DIRTY_CELL_DISPLAY_REFRESH_DEFINES_SVH

// same-cycle implication
`define DCDR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DCDR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/dcdr_pkg.sv -----
// shared types and constants for the dirty cell display refresh block
// no dependencies
package dcdr_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTRW  = 2;

  localparam logic [7:0] OP_MODE   = 8'h80;
  localparam logic [7:0] OP_GHADDR = 8'h42;
  localparam logic [7:0] OP_GHAREA = 8'h43;
  localparam logic [7:0] OP_DISP   = 8'h98;
  localparam logic [7:0] OP_APTR   = 8'h24;
  localparam logic [7:0] OP_AWR    = 8'hB0;
  localparam logic [7:0] OP_ARST   = 8'hB2;
  localparam logic [7:0] OP_WRINC  = 8'hC0;

  localparam logic [1:0] CFG_INVERT    = 2'd0;
  localparam logic [1:0] CFG_ROW_BYTES = 2'd1;
  localparam logic [1:0] CFG_MAX_GAP   = 2'd2;

  // output segments of one burst, in send order
  localparam int NSEG = 6;
  localparam logic [NSEG-1:0] SEG_OPEN  = 6'b000001;
  localparam logic [NSEG-1:0] SEG_ADDR  = 6'b000010;
  localparam logic [NSEG-1:0] SEG_AWR   = 6'b000100;
  localparam logic [NSEG-1:0] SEG_GAP   = 6'b001000;
  localparam logic [NSEG-1:0] SEG_PIX   = 6'b010000;
  localparam logic [NSEG-1:0] SEG_CLOSE = 6'b100000;

  typedef struct packed {
    logic        opening;
    logic        addr_ptr;
    logic        awr_start;
    logic        send_gaps;
    logic        pixel;
    logic        close_multi;
    logic        close_single;
    logic        store_gap;
    logic [15:0] addr;
    logic [7:0]  first_byte;
    logic [7:0]  cell_byte;
  } desc_t;

  function automatic logic [7:0] pix_byte(input logic [7:0] b, input logic inv);
    pix_byte = inv ? ~b : b;
  endfunction

endpackage

// ----- hdl/dcdr_front.sv -----
// front end: takes cells, tracks frame and run state, emits burst descriptors
// depends on dcdr_pkg
module dcdr_front import dcdr_pkg::*; #(
  parameter int MAX_GAP_CELLS = 15,
  parameter int ADDR_BITS     = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [3:0] max_gap,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_cell_byte,
  input  logic       in_cell_changed,
  input  logic       in_frame_end,
  input  logic       q_full,
  output logic       q_push,
  output desc_t      q_data
);

  localparam int GCW = $clog2(MAX_GAP_CELLS + 1);

  logic [ADDR_BITS-1:0] cnt_r, cnt_nxt;
  logic                 opening_sent_r, opening_sent_nxt;
  logic                 run_open_r, run_open_nxt;
  logic                 run_multi_r, run_multi_nxt;
  logic [7:0]           first_r, first_nxt;
  logic [GCW-1:0]       gc_r, gc_nxt;
  logic [GCW-1:0]       lim;
  logic [GCW:0]         gc_inc;
  logic                 accept;
  desc_t                d;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    lim = (32'(max_gap) < MAX_GAP_CELLS) ? GCW'(max_gap) : GCW'(MAX_GAP_CELLS);
    gc_inc = {1'b0, gc_r} + 1'b1;
    cnt_nxt = cnt_r;
    opening_sent_nxt = opening_sent_r;
    run_open_nxt = run_open_r;
    run_multi_nxt = run_multi_r;
    first_nxt = first_r;
    gc_nxt = gc_r;
    d = '0;
    d.addr = 16'(cnt_r);
    d.cell_byte = in_cell_byte;
    if (!run_open_r) begin
      if (in_cell_changed) begin
        d.opening = !opening_sent_r;
        d.addr_ptr = 1'b1;
        opening_sent_nxt = 1'b1;
        first_nxt = in_cell_byte;
        gc_nxt = '0;
        run_multi_nxt = 1'b0;
        if (lim == '0) begin
          d.close_single = 1'b1;
        end else begin
          run_open_nxt = 1'b1;
        end
      end
    end else if (in_cell_changed) begin
      d.awr_start = !run_multi_r;
      d.send_gaps = 1'b1;
      d.pixel = 1'b1;
      run_multi_nxt = 1'b1;
      gc_nxt = '0;
      if (lim == '0) begin
        d.close_multi = 1'b1;
        run_open_nxt = 1'b0;
        run_multi_nxt = 1'b0;
      end
    end else begin
      d.store_gap = 1'b1;
      gc_nxt = GCW'(gc_inc);
      if (gc_inc >= {1'b0, lim}) begin
        d.close_multi = run_multi_r;
        d.close_single = !run_multi_r;
        run_open_nxt = 1'b0;
        run_multi_nxt = 1'b0;
        gc_nxt = '0;
      end
    end
    if (in_frame_end) begin
      if (run_open_nxt) begin
        d.close_multi = run_multi_nxt;
        d.close_single = !run_multi_nxt;
        run_open_nxt = 1'b0;
        run_multi_nxt = 1'b0;
        gc_nxt = '0;
      end
      cnt_nxt = '0;
      opening_sent_nxt = 1'b0;
    end else begin
      cnt_nxt = cnt_r + 1'b1;
    end
    d.first_byte = first_nxt;
  end

  assign q_data = d;
  assign q_push = accept && (d.opening || d.addr_ptr || d.awr_start || d.send_gaps ||
                             d.pixel || d.close_multi || d.close_single || d.store_gap);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      opening_sent_r <= 1'b0;
      run_open_r <= 1'b0;
      run_multi_r <= 1'b0;
      gc_r <= '0;
    end else if (accept) begin
      cnt_r <= cnt_nxt;
      opening_sent_r <= opening_sent_nxt;
      run_open_r <= run_open_nxt;
      run_multi_r <= run_multi_nxt;
      gc_r <= gc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      first_r <= first_nxt;
    end
  end

endmodule

// ----- hdl/dcdr_fifo.sv -----
// descriptor queue between front and back end
// depends on dcdr_pkg
module dcdr_fifo import dcdr_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  valid,
  output desc_t head
);

  desc_t            data_r [QDEPTH];
  logic [QPTRW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTRW:0]   count_r, count_nxt;

  assign full  = (count_r == (QPTRW+1)'(QDEPTH));
  assign valid = (count_r != '0);
  assign head  = data_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- hdl/dcdr_back.sv -----
// back end: expands descriptors into controller bytes, holds gap bytes
// depends on dcdr_pkg and dirty_cell_display_refresh_defines.svh
`include "dirty_cell_display_refresh_defines.svh"

module dcdr_back import dcdr_pkg::*; #(
  parameter int MAX_GAP_CELLS = 15
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       invert,
  input  logic [7:0] row_bytes,
  input  logic       q_valid,
  input  desc_t      q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_is_command,
  output logic       out_last_of_burst
);

  localparam int GCW  = $clog2(MAX_GAP_CELLS + 1);
  localparam int GIW  = (MAX_GAP_CELLS > 1) ? $clog2(MAX_GAP_CELLS) : 1;
  localparam int SUBW = (GCW > 3) ? GCW : 3;

  desc_t           cur_r;
  logic [NSEG-1:0] mask_r, mask_nxt, seg;
  logic [SUBW-1:0] sub_r, sub_nxt;
  logic [GCW-1:0]  fill_r, gap_n_r;
  logic [7:0]      rd_r;
  logic [7:0]      gap_mem [MAX_GAP_CELLS];
  logic            out_valid_r, out_cmd_r, out_last_r;
  logic [7:0]      out_byte_r;
  logic            adv, emit, load, seg_last, last_burst, byte_cmd, we;
  logic [7:0]      byte_v;
  logic [GIW-1:0]  waddr, raddr;

  assign seg   = mask_r & (~mask_r + 1'b1);
  assign adv   = !out_valid_r || out_ready;
  assign emit  = (|mask_r) && adv;
  assign load  = !(|mask_r) && q_valid;
  assign q_pop = load;

  always_comb begin
    byte_v = 8'h00;
    byte_cmd = 1'b0;
    seg_last = 1'b0;
    case (seg)
      SEG_OPEN: begin
        seg_last = (sub_r == SUBW'(7));
        case (sub_r[2:0])
          3'd0: begin byte_v = OP_MODE; byte_cmd = 1'b1; end
          3'd1: byte_v = 8'h00;
          3'd2: byte_v = 8'h00;
          3'd3: begin byte_v = OP_GHADDR; byte_cmd = 1'b1; end
          3'd4: byte_v = row_bytes;
          3'd5: byte_v = 8'h00;
          3'd6: begin byte_v = OP_GHAREA; byte_cmd = 1'b1; end
          default: begin byte_v = OP_DISP; byte_cmd = 1'b1; end
        endcase
      end
      SEG_ADDR: begin
        seg_last = (sub_r == SUBW'(2));
        case (sub_r[1:0])
          2'd0: byte_v = cur_r.addr[7:0];
          2'd1: byte_v = cur_r.addr[15:8];
          default: begin byte_v = OP_APTR; byte_cmd = 1'b1; end
        endcase
      end
      SEG_AWR: begin
        seg_last = (sub_r == SUBW'(1));
        if (sub_r == '0) begin
          byte_v = OP_AWR;
          byte_cmd = 1'b1;
        end else begin
          byte_v = pix_byte(cur_r.first_byte, invert);
        end
      end
      SEG_GAP: begin
        seg_last = (({1'b0, sub_r} + 1'b1) == (SUBW+1)'(gap_n_r));
        byte_v = pix_byte(rd_r, invert);
      end
      SEG_PIX: begin
        seg_last = 1'b1;
        byte_v = pix_byte(cur_r.cell_byte, invert);
      end
      SEG_CLOSE: begin
        if (cur_r.close_multi) begin
          seg_last = 1'b1;
          byte_v = OP_ARST;
          byte_cmd = 1'b1;
        end else if (sub_r == '0) begin
          byte_v = pix_byte(cur_r.first_byte, invert);
        end else begin
          seg_last = 1'b1;
          byte_v = OP_WRINC;
          byte_cmd = 1'b1;
        end
      end
      default: begin
        byte_v = 8'h00;
      end
    endcase
    last_burst = seg_last && ((mask_r & ~seg) == '0);
  end

  always_comb begin
    mask_nxt = mask_r;
    sub_nxt = sub_r;
    if (load) begin
      mask_nxt = '0;
      if (q_head.opening) mask_nxt = mask_nxt | SEG_OPEN;
      if (q_head.addr_ptr) mask_nxt = mask_nxt | SEG_ADDR;
      if (q_head.awr_start) mask_nxt = mask_nxt | SEG_AWR;
      if (q_head.send_gaps && fill_r != '0) mask_nxt = mask_nxt | SEG_GAP;
      if (q_head.pixel) mask_nxt = mask_nxt | SEG_PIX;
      if (q_head.close_multi || q_head.close_single) mask_nxt = mask_nxt | SEG_CLOSE;
      sub_nxt = '0;
    end else if (emit) begin
      if (seg_last) begin
        mask_nxt = mask_r & ~seg;
        sub_nxt = '0;
      end else begin
        sub_nxt = sub_r + 1'b1;
      end
    end
  end

  assign we    = load && q_head.store_gap && (32'(fill_r) < MAX_GAP_CELLS);
  assign waddr = fill_r[GIW-1:0];
  assign raddr = sub_nxt[GIW-1:0];

  always_ff @(posedge clk) begin
    if (we) begin
      gap_mem[waddr] <= q_head.cell_byte;
    end
  end

  // write-through so a gap byte stored this cycle is seen at once
  always_ff @(posedge clk) begin
    if (32'(sub_nxt) < MAX_GAP_CELLS) begin
      rd_r <= (we && waddr == raddr) ? q_head.cell_byte : gap_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
      sub_r <= '0;
      fill_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r <= mask_nxt;
      sub_r <= sub_nxt;
      if (load) begin
        if (q_head.send_gaps || q_head.close_multi || q_head.close_single) begin
          fill_r <= '0;
        end else if (we) begin
          fill_r <= fill_r + 1'b1;
        end
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= q_head;
      gap_n_r <= fill_r;
    end
    if (emit) begin
      out_byte_r <= byte_v;
      out_cmd_r <= byte_cmd;
      out_last_r <= last_burst;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = out_byte_r;
  assign out_is_command    = out_cmd_r;
  assign out_last_of_burst = out_last_r;

  `DCDR_ASSERT_IMP(a_gap_in_range, (seg == SEG_GAP),
    ({1'b0, sub_r} < (SUBW+1)'(gap_n_r)), "gap read past stored count")
  `DCDR_ASSERT_IMP(a_fill_bound, 1'b1, (32'(fill_r) <= MAX_GAP_CELLS), "gap fill overflow")
  `DCDR_ASSERT_NXT(a_fill_step, (we && !q_head.close_multi && !q_head.close_single),
    (fill_r == GCW'($past(fill_r) + 1'b1)), "gap store did not advance fill")
  `DCDR_ASSERT_NXT(a_burst_done, (emit && last_burst), (mask_r == '0),
    "segments left after last byte of burst")

endmodule

// ----- hdl/dirty_cell_display_refresh.sv -----
// Dirty cell display refresh. Cells are taken one per cycle while the four-entry descriptor
// queue has room; a cell that is clean and outside a run sends nothing. The back end sends
// one controller byte per cycle into a registered output while out_ready allows, and picks
// up each queued descriptor only once the last one's bytes are all sent. The longest burst
// comes from a changed cell that joins a single-cell run after fourteen held gap bytes and
// ends the frame: B0, the first byte, the gaps, its own byte and B2. Held gap bytes live in
// a small memory in the back end and are replayed one per cycle while out_ready allows.
// Configuration writes take effect on the next cycle and are meant for idle periods.
// depends on dcdr_pkg, dcdr_front, dcdr_fifo, dcdr_back
module dirty_cell_display_refresh import dcdr_pkg::*; #(
  parameter int MAX_GAP_CELLS = 15,
  parameter int ADDR_BITS     = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_cell_byte,
  input  logic       in_cell_changed,
  input  logic       in_frame_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_is_command,
  output logic       out_last_of_burst
);

  logic       invert_r;
  logic [7:0] row_bytes_r;
  logic [3:0] max_gap_r;
  logic       q_full, q_push, q_pop, q_valid;
  desc_t      q_data, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_r <= 1'b0;
      row_bytes_r <= 8'd30;
      max_gap_r <= 4'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INVERT: invert_r <= cfg_wdata[0];
        CFG_ROW_BYTES: row_bytes_r <= cfg_wdata;
        CFG_MAX_GAP: max_gap_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  dcdr_front #(
    .MAX_GAP_CELLS(MAX_GAP_CELLS),
    .ADDR_BITS(ADDR_BITS)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .max_gap(max_gap_r),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_cell_byte(in_cell_byte),
    .in_cell_changed(in_cell_changed),
    .in_frame_end(in_frame_end),
    .q_full(q_full),
    .q_push(q_push),
    .q_data(q_data)
  );

  dcdr_fifo u_fifo (
    .clk(clk),
    .rst_n(rst_n),
    .push(q_push),
    .push_data(q_data),
    .full(q_full),
    .pop(q_pop),
    .valid(q_valid),
    .head(q_head)
  );

  dcdr_back #(
    .MAX_GAP_CELLS(MAX_GAP_CELLS)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .invert(invert_r),
    .row_bytes(row_bytes_r),
    .q_valid(q_valid),
    .q_head(q_head),
    .q_pop(q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte(out_byte),
    .out_is_command(out_is_command),
    .out_last_of_burst(out_last_of_burst)
  );

endmodule

// ----- sim/dcdr_stream_checker.sv -----
// checker for the dirty cell display refresh block: follows config writes and cell transfers,
// predicts the controller byte stream and compares every output transfer field by field
// depends on dcdr_pkg
module dcdr_stream_checker import dcdr_pkg::*; #(
  parameter int GAP_CELLS = 15,
  parameter int ADDR_W    = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_cell_byte,
  input  logic       in_cell_changed,
  input  logic       in_frame_end,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       out_is_command,
  input  logic       out_last_of_burst,
  input  logic       end_of_test,
  output int         mismatches,
  output int         outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] value;
    logic       cmd;
    logic       last;
  } ctl_byte_t;

  ctl_byte_t ctl_bytes_due[$];
  ctl_byte_t head;

  logic             inv_data;
  logic [7:0]       row_len;
  logic [3:0]       max_gap;

  logic [ADDR_W-1:0] cell_ctr;
  logic              opening_done;
  logic              run_open;
  logic              run_multi;
  logic [7:0]        first_byte;
  int                gap_cnt;
  logic [7:0]        gap_mem [GAP_CELLS];

  int   fail_count = 0;
  int   waiting = 0;
  logic leftover_seen = 1'b0;

  assign mismatches  = fail_count;
  assign outstanding = waiting;

  function automatic void emit(input logic [7:0] value, input logic cmd);
    ctl_byte_t c;
    c.value = value;
    c.cmd   = cmd;
    c.last  = 1'b0;
    ctl_bytes_due.push_back(c);
  endfunction

  function automatic void emit_pixel(input logic [7:0] value);
    emit(inv_data ? ~value : value, 1'b0);
  endfunction

  function automatic void close_run();
    if (run_multi) begin
      emit(OP_ARST, 1'b1);
    end else begin
      emit_pixel(first_byte);
      emit(OP_WRINC, 1'b1);
    end
    run_open  = 1'b0;
    run_multi = 1'b0;
    gap_cnt   = 0;
  endfunction

  function automatic void encode_cell(input logic [7:0] b, input logic chg, input logic fe);
    int          limit;
    int          before_cnt;
    logic [15:0] addr;
    ctl_byte_t   tail;
    limit      = (int'(max_gap) < GAP_CELLS) ? int'(max_gap) : GAP_CELLS;
    addr       = 16'(cell_ctr);
    before_cnt = ctl_bytes_due.size();
    if (!run_open) begin
      if (chg) begin
        if (!opening_done) begin
          emit(OP_MODE, 1'b1);
          emit(8'h00, 1'b0);
          emit(8'h00, 1'b0);
          emit(OP_GHADDR, 1'b1);
          emit(row_len, 1'b0);
          emit(8'h00, 1'b0);
          emit(OP_GHAREA, 1'b1);
          emit(OP_DISP, 1'b1);
          opening_done = 1'b1;
        end
        emit(addr[7:0], 1'b0);
        emit(addr[15:8], 1'b0);
        emit(OP_APTR, 1'b1);
        run_open   = 1'b1;
        run_multi  = 1'b0;
        first_byte = b;
        gap_cnt    = 0;
        if (gap_cnt >= limit) close_run();
      end
    end else if (chg) begin
      if (!run_multi) begin
        emit(OP_AWR, 1'b1);
        emit_pixel(first_byte);
        run_multi = 1'b1;
      end
      for (int k = 0; k < gap_cnt && k < GAP_CELLS; k++) emit_pixel(gap_mem[k]);
      gap_cnt = 0;
      emit_pixel(b);
      if (gap_cnt >= limit) close_run();
    end else begin
      if (gap_cnt < GAP_CELLS) gap_mem[gap_cnt] = b;
      if (gap_cnt < 255) gap_cnt++;
      if (gap_cnt >= limit) close_run();
    end
    if (fe) begin
      if (run_open) close_run();
      cell_ctr     = '0;
      opening_done = 1'b0;
    end else begin
      cell_ctr = cell_ctr + 1'b1;
    end
    if (ctl_bytes_due.size() > before_cnt) begin
      tail = ctl_bytes_due.pop_back();
      tail.last = 1'b1;
      ctl_bytes_due.push_back(tail);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      inv_data     = 1'b0;
      row_len      = 8'd30;
      max_gap      = 4'd4;
      cell_ctr     = '0;
      opening_done = 1'b0;
      run_open     = 1'b0;
      run_multi    = 1'b0;
      gap_cnt      = 0;
      ctl_bytes_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_INVERT:    inv_data = cfg_wdata[0];
          CFG_ROW_BYTES: row_len  = cfg_wdata;
          CFG_MAX_GAP:   max_gap  = cfg_wdata[3:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) encode_cell(in_cell_byte, in_cell_changed, in_frame_end);
      if (out_valid && out_ready) begin
        if (ctl_bytes_due.size() == 0) begin
          $error("unexpected transfer: out_byte %h out_is_command %b out_last_of_burst %b",
                 out_byte, out_is_command, out_last_of_burst);
          fail_count++;
        end else begin
          head = ctl_bytes_due.pop_front();
          if (out_byte !== head.value) begin
            $error("out_byte: expected %h actual %h", head.value, out_byte);
            fail_count++;
          end
          if (out_is_command !== head.cmd) begin
            $error("out_is_command: expected %b actual %b", head.cmd, out_is_command);
            fail_count++;
          end
          if (out_last_of_burst !== head.last) begin
            $error("out_last_of_burst: expected %b actual %b", head.last, out_last_of_burst);
            fail_count++;
          end
        end
      end
      if (end_of_test && !leftover_seen && ctl_bytes_due.size() != 0) begin
        $error("%0d expected bytes never transferred", ctl_bytes_due.size());
        fail_count++;
        leftover_seen = 1'b1;
      end
    end
    waiting = ctl_bytes_due.size();
  end

endmodule

// ----- sim/testbench.sv -----
// top of the dirty cell display refresh testbench: clock, reset, config writes and cell stimulus
// with random idling on both channels; verdict comes from dcdr_stream_checker
// depends on dcdr_pkg, dirty_cell_display_refresh, dcdr_stream_checker
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dcdr_pkg::*;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_INVERT;
  logic [7:0] cfg_wdata = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_cell_byte = 8'h00;
  logic       in_cell_changed = 1'b0;
  logic       in_frame_end = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_is_command;
  logic       out_last_of_burst;
  logic       end_of_test = 1'b0;
  logic       steady = 1'b0;
  int         mismatches;
  int         outstanding;

  dirty_cell_display_refresh dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_cell_byte(in_cell_byte),
    .in_cell_changed(in_cell_changed), .in_frame_end(in_frame_end),
    .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
    .out_is_command(out_is_command), .out_last_of_burst(out_last_of_burst)
  );

  dcdr_stream_checker chk (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_cell_byte(in_cell_byte),
    .in_cell_changed(in_cell_changed), .in_frame_end(in_frame_end),
    .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
    .out_is_command(out_is_command), .out_last_of_burst(out_last_of_burst),
    .end_of_test(end_of_test), .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(negedge clk) out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 30);

  task automatic send_cell(input logic [7:0] b, input logic chg, input logic fe);
    @(negedge clk);
    if (!steady) begin
      while ($urandom_range(99) < 30) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid        <= 1'b1;
    in_cell_byte    <= b;
    in_cell_changed <= chg;
    in_frame_end    <= fe;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(input logic inv, input logic [7:0] row, input logic [3:0] gap);
    cfg_write(CFG_INVERT, {7'd0, inv});
    cfg_write(CFG_ROW_BYTES, row);
    cfg_write(CFG_MAX_GAP, {4'd0, gap});
  endtask

  // drain the output stream, then let the descriptor queue empty out
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  initial begin
    int chg_pct;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset setting: opening, merged run, gap close, single run closed by frame end
    send_cell(8'hFF, 1'b1, 1'b0);
    send_cell(8'hAA, 1'b0, 1'b0);
    send_cell(8'h55, 1'b0, 1'b0);
    send_cell(8'h3C, 1'b1, 1'b0);
    for (int i = 0; i < 4; i++) send_cell(8'(8'h01 << i), 1'b0, 1'b0);
    send_cell(8'h80, 1'b1, 1'b1);
    settle();

    // inverted data, zero row length, zero gap closes every run at once
    apply_setting(1'b1, 8'd0, 4'd0);
    send_cell(8'h0F, 1'b1, 1'b0);
    send_cell(8'hF0, 1'b1, 1'b1);
    settle();

    // widest gap: longest burst on the joining cell plus frame end close
    apply_setting(1'b0, 8'd255, 4'd15);
    send_cell(8'h12, 1'b1, 1'b0);
    for (int i = 0; i < 14; i++) send_cell(pick_byte(), 1'b0, 1'b0);
    send_cell(8'hE7, 1'b1, 1'b1);
    settle();

    // gap limit lowered while a run is open
    cfg_write(CFG_MAX_GAP, 8'd8);
    send_cell(8'h5A, 1'b1, 1'b0);
    send_cell(8'h11, 1'b0, 1'b0);
    send_cell(8'h22, 1'b0, 1'b0);
    settle();
    apply_setting(1'b1, 8'd30, 4'd1);
    send_cell(8'h33, 1'b0, 1'b0);
    send_cell(8'h44, 1'b0, 1'b1);
    settle();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: apply_setting(1'b0, 8'd1, 4'd15);
        1: apply_setting(1'b1, 8'd255, 4'd0);
        default: apply_setting(1'($urandom_range(1)), 8'($urandom_range(255)),
                               4'($urandom_range(15)));
      endcase
      steady = (p == 2 || p == 3);
      case ($urandom_range(2))
        0: chg_pct = 15;
        1: chg_pct = 40;
        default: chg_pct = 75;
      endcase
      for (int i = 0; i < 15; i++)
        send_cell(pick_byte(), $urandom_range(99) < chg_pct, $urandom_range(99) < 6);
      settle();
    end

    steady = 1'b0;
    @(negedge clk);
    end_of_test <= 1'b1;
    repeat (2) @(negedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
